FILE: rtl/core/chord_sensor_key_qualifier_macros.svh
// assertion macros for the chord qualifier, included by csk_merge
`ifndef CHORD_SENSOR_KEY_QUALIFIER_MACROS_SVH
`define CHORD_SENSOR_KEY_QUALIFIER_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define CSK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define CSK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/csk_pkg.sv
// shared types, constants and the usage map of the chord qualifier
`default_nettype none

package csk_pkg;

   // fixed geometry of a scan
   localparam int CHANNEL_COUNT = 5;
   localparam int SAMPLE_BITS   = 12;
   localparam int MARGIN_BITS   = 8;
   localparam int TIME_BITS     = 48;
   localparam int CONFIRM_BITS  = 24;
   localparam int CHORD_BITS    = 5;
   localparam int USAGE_BITS    = 8;
   localparam int INDEX_BITS    = 3;
   localparam int DIFF10_BITS   = SAMPLE_BITS + 4;
   localparam int MARGINS_BITS  = MARGIN_BITS * CHANNEL_COUNT;

   // detection mode codes
   localparam logic MODE_STABILITY = 1'b0;
   localparam logic MODE_THRESHOLD = 1'b1;

   // control register indexes
   localparam logic [INDEX_BITS-1:0] CSR_DETECT_MODE     = 3'd0;
   localparam logic [INDEX_BITS-1:0] CSR_PRESS_THRESHOLD = 3'd1;
   localparam logic [INDEX_BITS-1:0] CSR_RELEASE_MARGINS = 3'd2;
   localparam logic [INDEX_BITS-1:0] CSR_QUIET_LEVEL     = 3'd3;
   localparam logic [INDEX_BITS-1:0] CSR_CONFIRM_TIME    = 3'd4;

   // control register reset values
   localparam logic                    RESET_DETECT_MODE     = MODE_STABILITY;
   localparam logic [SAMPLE_BITS-1:0]  RESET_PRESS_THRESHOLD = 12'd20;
   localparam logic [MARGINS_BITS-1:0] RESET_RELEASE_MARGINS = 40'h0A14321E1E;
   localparam logic [SAMPLE_BITS-1:0]  RESET_QUIET_LEVEL     = 12'd10;
   localparam logic [CONFIRM_BITS-1:0] RESET_CONFIRM_TIME    = 24'd300000;

   // chord codes with special meaning
   localparam logic [CHORD_BITS-1:0] CHORD_NONE        = 5'd0;
   localparam logic [CHORD_BITS-1:0] CHORD_FIRST_LETTER = 5'd1;
   localparam logic [CHORD_BITS-1:0] CHORD_LAST_LETTER = 5'd26;
   localparam logic [CHORD_BITS-1:0] CHORD_BACKSPACE   = 5'd30;
   localparam logic [CHORD_BITS-1:0] CHORD_ENTER       = 5'd31;

   // hid usages
   localparam logic [USAGE_BITS-1:0] USAGE_NONE        = 8'd0;
   localparam logic [USAGE_BITS-1:0] USAGE_LETTER_BASE = 8'd3;
   localparam logic [USAGE_BITS-1:0] USAGE_ENTER       = 8'd40;
   localparam logic [USAGE_BITS-1:0] USAGE_BACKSPACE   = 8'd42;
   localparam logic [USAGE_BITS-1:0] USAGE_SPACE       = 8'd44;

   // flags one lane hands to the merge stage
   typedef struct packed {
      logic pressed;
      logic unstable;
   } csk_lane_type;

   // one response
   typedef struct packed {
      logic [USAGE_BITS-1:0] hid_usage;
      logic [CHORD_BITS-1:0] chord_code;
      logic                  key_fired;
      logic [CHORD_BITS-1:0] motor_drive;
   } csk_result_type;

   // chord to hid usage
   function automatic logic [USAGE_BITS-1:0] usage_of(input logic [CHORD_BITS-1:0] chord);
      logic [USAGE_BITS-1:0] usage;
      case (chord) inside
         CHORD_NONE:                           usage = USAGE_NONE;
         CHORD_ENTER:                          usage = USAGE_ENTER;
         CHORD_BACKSPACE:                      usage = USAGE_BACKSPACE;
         [CHORD_FIRST_LETTER:CHORD_LAST_LETTER]:
            usage = USAGE_LETTER_BASE + {{(USAGE_BITS-CHORD_BITS){1'b0}}, chord};
         default:                              usage = USAGE_SPACE;
      endcase
      return usage;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/chord_sensor_key_qualifier.sv
// a response is registered; it waits in the skid stage while the output is held
// throughput: one request per cycle; a two-entry output buffer keeps req_ready high
//   while one response waits, so the rate is set only by rsp_ready
// reset (synchronous, active high) clears lane flags, previous samples, candidate,
//   deadline, sent latch and the output buffer and loads control register defaults
`default_nettype none

module chord_sensor_key_qualifier (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0]      req_sample_a,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0]      req_sample_b,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0]      req_sample_c,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0]      req_sample_d,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0]      req_sample_e,
   input  wire logic [csk_pkg::TIME_BITS-1:0]        req_now_us,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [csk_pkg::USAGE_BITS-1:0]            rsp_hid_usage,
   output logic [csk_pkg::CHORD_BITS-1:0]            rsp_chord_code,
   output logic                                      rsp_key_fired,
   output logic [csk_pkg::CHORD_BITS-1:0]            rsp_motor_drive,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [csk_pkg::INDEX_BITS-1:0]       csr_index,
   input  wire logic [csk_pkg::MARGINS_BITS-1:0]     csr_wdata
);
   import csk_pkg::*;

   logic                    detect_mode_ff;
   logic [SAMPLE_BITS-1:0]  press_threshold_ff;
   logic [MARGINS_BITS-1:0] release_margins_ff;
   logic [SAMPLE_BITS-1:0]  quiet_level_ff;
   logic [CONFIRM_BITS-1:0] confirm_time_ff;

   logic                    advance;
   logic [SAMPLE_BITS-1:0]  samples [CHANNEL_COUNT];
   csk_lane_type            lanes   [CHANNEL_COUNT];
   csk_result_type          rsp_data;

   // control registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_mode_ff     <= RESET_DETECT_MODE;
         press_threshold_ff <= RESET_PRESS_THRESHOLD;
         release_margins_ff <= RESET_RELEASE_MARGINS;
         quiet_level_ff     <= RESET_QUIET_LEVEL;
         confirm_time_ff    <= RESET_CONFIRM_TIME;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DETECT_MODE:     detect_mode_ff     <= csr_wdata[0];
            CSR_PRESS_THRESHOLD: press_threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_RELEASE_MARGINS: release_margins_ff <= csr_wdata[MARGINS_BITS-1:0];
            CSR_QUIET_LEVEL:     quiet_level_ff     <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_CONFIRM_TIME:    confirm_time_ff    <= csr_wdata[CONFIRM_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign advance = req_valid & req_ready;

   // samples in channel order
   assign samples[0] = req_sample_a;
   assign samples[1] = req_sample_b;
   assign samples[2] = req_sample_c;
   assign samples[3] = req_sample_d;
   assign samples[4] = req_sample_e;

   // one detector lane per channel
   for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_lane
      csk_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .advance         (advance),
         .detect_mode     (detect_mode_ff),
         .press_threshold (press_threshold_ff),
         .release_margin  (release_margins_ff[MARGIN_BITS*g +: MARGIN_BITS]),
         .quiet_level     (quiet_level_ff),
         .sample          (samples[g]),
         .lane_next       (lanes[g])
      );
   end

   // chord qualification and response buffer
   csk_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .lanes           (lanes),
      .now_us          (req_now_us),
      .confirm_time_us (confirm_time_ff),
      .rsp_ready       (rsp_ready),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

   assign rsp_hid_usage   = rsp_data.hid_usage;
   assign rsp_chord_code  = rsp_data.chord_code;
   assign rsp_key_fired   = rsp_data.key_fired;
   assign rsp_motor_drive = rsp_data.motor_drive;

endmodule

`default_nettype wire

FILE: rtl/core/csk_lane.sv
// one channel detector: pressed and unstable flags plus the previous sample
`default_nettype none

module csk_lane (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            detect_mode,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0] press_threshold,
   input  wire logic [csk_pkg::MARGIN_BITS-1:0] release_margin,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0] quiet_level,
   input  wire logic [csk_pkg::SAMPLE_BITS-1:0] sample,
   output csk_pkg::csk_lane_type                lane_next
);
   import csk_pkg::*;

   logic                   pressed_ff, pressed_in;
   logic                   unstable_ff, unstable_in;
   logic [SAMPLE_BITS-1:0] prev_ff;
   logic [SAMPLE_BITS-1:0] diff;
   logic [DIFF10_BITS-1:0] diff_wide;
   logic [DIFF10_BITS-1:0] diff10;
   logic [DIFF10_BITS-1:0] prev_wide;
   logic [SAMPLE_BITS:0]   release_sum;
   logic                   below_release;

   // absolute change times ten as two shifts
   always_comb begin
      diff      = (sample >= prev_ff) ? (sample - prev_ff) : (prev_ff - sample);
      diff_wide = {{(DIFF10_BITS-SAMPLE_BITS){1'b0}}, diff};
      diff10    = (diff_wide << 3) + (diff_wide << 1);
      prev_wide = {{(DIFF10_BITS-SAMPLE_BITS){1'b0}}, prev_ff};
   end

   // sample below threshold minus margin, written as sample plus margin below threshold
   always_comb begin
      release_sum   = {1'b0, sample}
                    + {{(SAMPLE_BITS+1-MARGIN_BITS){1'b0}}, release_margin};
      below_release = release_sum < {1'b0, press_threshold};
   end

   // next flags for both detectors
   always_comb begin
      pressed_in  = pressed_ff;
      unstable_in = unstable_ff;
      if (detect_mode == MODE_THRESHOLD) begin
         if (!pressed_ff) begin
            pressed_in = sample >= press_threshold;
         end else if (below_release) begin
            pressed_in = 1'b0;
         end
      end else if (sample <= quiet_level) begin
         pressed_in  = 1'b0;
         unstable_in = 1'b0;
      end else if (!pressed_ff) begin
         if (diff10 <= prev_wide) begin
            pressed_in  = 1'b1;
            unstable_in = 1'b0;
         end
      end else if (diff10 >= prev_wide) begin
         unstable_in = 1'b1;
      end
   end

   assign lane_next.pressed  = pressed_in;
   assign lane_next.unstable = unstable_in;

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff  <= 1'b0;
         unstable_ff <= 1'b0;
         prev_ff     <= '0;
      end else if (advance) begin
         pressed_ff  <= pressed_in;
         unstable_ff <= unstable_in;
         prev_ff     <= sample;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/csk_merge.sv
// chord qualification over the lane flags, usage map and response buffering
`default_nettype none

module csk_merge (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  csk_pkg::csk_lane_type                 lanes [csk_pkg::CHANNEL_COUNT],
   input  wire logic [csk_pkg::TIME_BITS-1:0]    now_us,
   input  wire logic [csk_pkg::CONFIRM_BITS-1:0] confirm_time_us,
   input  wire logic                             rsp_ready,
   output logic                                  req_ready,
   output logic                                  rsp_valid,
   output csk_pkg::csk_result_type               rsp_data
);
   import csk_pkg::*;

   `include "chord_sensor_key_qualifier_macros.svh"

   logic [CHORD_BITS-1:0] candidate_ff, candidate_in;
   logic [TIME_BITS-1:0]  deadline_ff, deadline_in;
   logic                  sent_ff, sent_in;
   logic [CHORD_BITS-1:0] chord;
   logic                  any_unstable;
   logic [TIME_BITS:0]    deadline_sum;
   logic [TIME_BITS-1:0]  deadline_sat;
   csk_result_type        result;

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   csk_result_type        out_data_ff, out_data_in;
   csk_result_type        skid_data_ff, skid_data_in;
   logic                  take;

   // gather the lanes into a chord
   always_comb begin
      chord        = '0;
      any_unstable = 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         chord[i]     = lanes[i].pressed;
         any_unstable = any_unstable | lanes[i].unstable;
      end
   end

   // saturating deadline
   always_comb begin
      deadline_sum = {1'b0, now_us} + {{(TIME_BITS+1-CONFIRM_BITS){1'b0}}, confirm_time_us};
      deadline_sat = deadline_sum[TIME_BITS] ? '1 : deadline_sum[TIME_BITS-1:0];
   end

   // chord qualification
   always_comb begin
      candidate_in       = candidate_ff;
      deadline_in        = deadline_ff;
      sent_in            = sent_ff;
      result.hid_usage   = USAGE_NONE;
      result.chord_code  = chord;
      result.key_fired   = 1'b0;
      result.motor_drive = '0;
      if (chord == CHORD_NONE) begin
         candidate_in = CHORD_NONE;
         sent_in      = 1'b0;
      end else if (sent_ff) begin
         result.motor_drive = '0;
      end else if (any_unstable) begin
         result.motor_drive = chord;
      end else if (candidate_ff != chord) begin
         deadline_in        = deadline_sat;
         candidate_in       = chord;
         result.motor_drive = chord;
      end else if (now_us < deadline_ff) begin
         result.motor_drive = chord;
      end else begin
         sent_in            = 1'b1;
         result.motor_drive = '1;
         result.key_fired   = 1'b1;
         result.hid_usage   = usage_of(chord);
      end
   end

   // qualifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff <= '0;
         deadline_ff  <= '0;
         sent_ff      <= 1'b0;
      end else if (advance) begin
         candidate_ff <= candidate_in;
         deadline_ff  <= deadline_in;
         sent_ff      <= sent_in;
      end
   end

   // output register with a skid stage behind it
   assign take      = out_valid_ff & rsp_ready;
   assign req_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (advance) begin
         if (!out_valid_ff || take) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   `CSK_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full with output empty")
   `CSK_ASSERT_NEXT(a_fire_sets_latch, advance && result.key_fired, sent_ff, "send did not latch")
   `CSK_ASSERT_NOW(a_latch_blocks_fire, advance && sent_ff, !result.key_fired, "second send before release")
   `CSK_ASSERT_NOW(a_fire_has_usage, advance && result.key_fired, result.hid_usage != USAGE_NONE, "send without usage")

endmodule

`default_nettype wire
